@@ rtl/core/ucd_pkg.sv @@
// Package for the undirected graph cycle detector.
// Holds request codes, sizing defaults and the controller/datapath command and status structs.
// No dependencies.
package ucd_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam logic [6:0] VC_RESET = 7'd64;

	// Width of one slice of the neighbor mask that the push step examines per cycle.
	localparam int CHUNK_BITS = 8;
	localparam int CHUNK_IW = 3;

	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_RUN = 2'd2;

	typedef struct packed {
		logic ready;
		logic sweep;
		logic scan_clr;
		logic scan_inc;
		logic run_init;
		logic rd_a;
		logic wr_a;
		logic wr_b;
		logic root;
		logic pop;
		logic load;
		logic check;
		logic push;
		logic chunk_inc;
		logic publish;
		logic res_status;
		logic res_cycle;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic [1:0] req;
		logic edge_ok;
		logic sweep_last;
		logic scan_end;
		logic scan_visited;
		logic depth_zero;
		logic hit;
		logic chunk_nz;
		logic chunk_last;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/core/ucd_if.sv @@
// Valid/ready channel interfaces for request items and result items.
// Depends on nothing; field widths follow the request and result formats.
interface ucd_item_if;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [5:0] vertex_a;
	logic [5:0] vertex_b;

	modport source (output valid, output req_type, output vertex_a, output vertex_b,
		input ready);
	modport sink (input valid, input req_type, input vertex_a, input vertex_b,
		output ready);
endinterface

interface ucd_result_if;
	logic valid;
	logic ready;
	logic status;
	logic cycle_found;

	modport source (output valid, output status, output cycle_found, input ready);
	modport sink (input valid, input status, input cycle_found, output ready);
endinterface

@@ rtl/core/ucd_ctrl.sv @@
// Sequencer for the cycle detector: decodes requests and steps the search.
// Depends on ucd_pkg for the command and status structs and request codes.
module ucd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  ucd_pkg::stat_t stat,
	output ucd_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_INIT     = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_DISP     = 4'd2;
	localparam logic [3:0] S_EDGE_RB  = 4'd3;
	localparam logic [3:0] S_EDGE_WB  = 4'd4;
	localparam logic [3:0] S_CLEAR    = 4'd5;
	localparam logic [3:0] S_SCAN     = 4'd6;
	localparam logic [3:0] S_POP      = 4'd7;
	localparam logic [3:0] S_LOAD     = 4'd8;
	localparam logic [3:0] S_CHECK    = 4'd9;
	localparam logic [3:0] S_PUSH     = 4'd10;
	localparam logic [3:0] S_RESP     = 4'd11;

	logic [3:0] state_q, state_d;
	logic res_status_q, res_status_d;
	logic res_cycle_q, res_cycle_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		res_status_d = res_status_q;
		res_cycle_d = res_cycle_q;
		cmd.res_status = res_status_q;
		cmd.res_cycle = res_cycle_q;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
				cmd.scan_inc = 1'b1;
				if (stat.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (stat.in_valid) state_d = S_DISP;
			end
			S_DISP: begin
				res_status_d = 1'b0;
				res_cycle_d = 1'b0;
				unique case (stat.req)
					ucd_pkg::REQ_ADD: begin
						if (stat.edge_ok) begin
							cmd.rd_a = 1'b1;
							state_d = S_EDGE_RB;
						end else begin
							res_status_d = 1'b1;
							state_d = S_RESP;
						end
					end
					ucd_pkg::REQ_CLEAR: begin
						cmd.scan_clr = 1'b1;
						state_d = S_CLEAR;
					end
					ucd_pkg::REQ_RUN: begin
						cmd.run_init = 1'b1;
						state_d = S_SCAN;
					end
					default: state_d = S_RESP;
				endcase
			end
			S_EDGE_RB: begin
				cmd.wr_a = 1'b1;
				state_d = S_EDGE_WB;
			end
			S_EDGE_WB: begin
				cmd.wr_b = 1'b1;
				state_d = S_RESP;
			end
			S_CLEAR: begin
				cmd.sweep = 1'b1;
				cmd.scan_inc = 1'b1;
				if (stat.sweep_last) state_d = S_RESP;
			end
			S_SCAN: begin
				priority if (stat.scan_end) begin
					state_d = S_RESP;
				end else if (stat.scan_visited) begin
					cmd.scan_inc = 1'b1;
				end else begin
					cmd.root = 1'b1;
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (stat.depth_zero) begin
					cmd.scan_inc = 1'b1;
					state_d = S_SCAN;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.hit) begin
					res_cycle_d = 1'b1;
					state_d = S_RESP;
				end else begin
					cmd.check = 1'b1;
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				priority if (stat.chunk_nz) begin
					cmd.push = 1'b1;
				end else if (stat.chunk_last) begin
					state_d = S_POP;
				end else begin
					cmd.chunk_inc = 1'b1;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.publish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			res_status_q <= 1'b0;
			res_cycle_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_status_q <= res_status_d;
			res_cycle_q <= res_cycle_d;
		end
	end

endmodule

@@ rtl/core/ucd_dp.sv @@
// Datapath for the cycle detector: adjacency, parent and stack memories, visited marks,
// counters, the neighbor mask walker and the result register.
// Depends on ucd_pkg and on the channel interfaces in ucd_if.sv.
module ucd_dp #(
	parameter int MAX_VERTICES = ucd_pkg::MAX_VERTICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_wdata,
	ucd_item_if.sink            item,
	ucd_result_if.source        result,
	input  ucd_pkg::cmd_t       cmd,
	output ucd_pkg::stat_t      stat
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int NW = (CW > 7) ? CW : 7;
	localparam int CHUNKS = (MAX_VERTICES + ucd_pkg::CHUNK_BITS - 1) / ucd_pkg::CHUNK_BITS;
	localparam int CKW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int PW = CHUNKS * ucd_pkg::CHUNK_BITS;
	localparam int FW = CKW + ucd_pkg::CHUNK_IW;

	logic [6:0] vc_q;
	logic [1:0] req_q;
	logic [5:0] a_q, b_q;

	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] adj_rd_q;
	logic [VW-1:0] stack_mem [MAX_VERTICES];
	logic [VW-1:0] stack_rd_q;
	logic [VW-1:0] par_mem [MAX_VERTICES];
	logic [VW-1:0] par_rd_q;

	logic [MAX_VERTICES-1:0] visited_q;
	logic [NW-1:0] scan_q;
	logic [CW-1:0] depth_q;
	logic [VW-1:0] cur_q;
	logic [PW-1:0] cand_q;
	logic [CKW-1:0] chunk_q;

	logic out_valid_q, out_status_q, out_cycle_q;

	logic [NW-1:0] n_eff, vc_ext, a_ext, b_ext;
	logic [MAX_VERTICES-1:0] act_mask, row_m, par_oh;
	logic [VW-1:0] a_idx, b_idx, scan_idx, push_v;
	logic [CW-1:0] depth_m1;
	logic [ucd_pkg::CHUNK_BITS-1:0] chunk_bits;
	logic [ucd_pkg::CHUNK_IW-1:0] chunk_p;
	logic [FW-1:0] vfull;

	logic adj_we, adj_re;
	logic [VW-1:0] adj_waddr, adj_raddr;
	logic [MAX_VERTICES-1:0] adj_wdata;

	assign vc_ext = NW'(vc_q);
	assign n_eff = (vc_ext < NW'(MAX_VERTICES)) ? vc_ext : NW'(MAX_VERTICES);
	assign a_ext = NW'(a_q);
	assign b_ext = NW'(b_q);
	assign a_idx = a_ext[VW-1:0];
	assign b_idx = b_ext[VW-1:0];
	assign scan_idx = scan_q[VW-1:0];
	assign depth_m1 = depth_q - 1'b1;

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			act_mask[i] = (NW'(i) < n_eff);
		end
	end

	assign row_m = adj_rd_q & act_mask;
	assign par_oh = MAX_VERTICES'(1) << par_rd_q;

	assign chunk_bits = ucd_pkg::CHUNK_BITS'(cand_q >> {chunk_q, {ucd_pkg::CHUNK_IW{1'b0}}});

	always_comb begin
		chunk_p = '0;
		for (int i = ucd_pkg::CHUNK_BITS - 1; i >= 0; i--) begin
			if (chunk_bits[i]) chunk_p = ucd_pkg::CHUNK_IW'(i);
		end
	end

	assign vfull = {chunk_q, chunk_p};
	assign push_v = vfull[VW-1:0];

	assign item.ready = cmd.ready;
	assign result.valid = out_valid_q;
	assign result.status = out_status_q;
	assign result.cycle_found = out_cycle_q;

	assign stat.in_valid = item.valid;
	assign stat.req = req_q;
	assign stat.edge_ok = (a_ext < n_eff) && (b_ext < n_eff) && (a_q != b_q);
	assign stat.sweep_last = (scan_q == NW'(MAX_VERTICES - 1));
	assign stat.scan_end = (scan_q == n_eff);
	assign stat.scan_visited = visited_q[scan_idx];
	assign stat.depth_zero = (depth_q == '0);
	assign stat.hit = |(row_m & visited_q & ~par_oh);
	assign stat.chunk_nz = |chunk_bits;
	assign stat.chunk_last = (chunk_q == CKW'(CHUNKS - 1));
	assign stat.out_free = !out_valid_q || result.ready;

	always_comb begin
		adj_we = 1'b0;
		adj_waddr = scan_idx;
		adj_wdata = '0;
		priority if (cmd.sweep) begin
			adj_we = 1'b1;
		end else if (cmd.wr_a) begin
			adj_we = 1'b1;
			adj_waddr = a_idx;
			adj_wdata = adj_rd_q | (MAX_VERTICES'(1) << b_q);
		end else if (cmd.wr_b) begin
			adj_we = 1'b1;
			adj_waddr = b_idx;
			adj_wdata = adj_rd_q | (MAX_VERTICES'(1) << a_q);
		end else begin
			adj_we = 1'b0;
		end
	end

	always_comb begin
		adj_re = cmd.rd_a || cmd.wr_a || cmd.load;
		priority if (cmd.rd_a) begin
			adj_raddr = a_idx;
		end else if (cmd.wr_a) begin
			adj_raddr = b_idx;
		end else begin
			adj_raddr = stack_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
		if (adj_re) adj_rd_q <= adj_mem[adj_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.root) begin
			stack_mem[depth_q[VW-1:0]] <= scan_idx;
			par_mem[scan_idx] <= scan_idx;
		end else if (cmd.push) begin
			stack_mem[depth_q[VW-1:0]] <= push_v;
			par_mem[push_v] <= cur_q;
		end
		if (cmd.pop) stack_rd_q <= stack_mem[depth_m1[VW-1:0]];
		if (cmd.load) par_rd_q <= par_mem[stack_rd_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && item.valid) begin
			req_q <= item.req_type;
			a_q <= item.vertex_a;
			b_q <= item.vertex_b;
		end
		if (cmd.load) cur_q <= stack_rd_q;
		if (cmd.check) begin
			cand_q <= PW'(row_m & ~visited_q);
			chunk_q <= '0;
		end else begin
			if (cmd.push) cand_q <= cand_q & ~(PW'(1) << vfull);
			if (cmd.chunk_inc) chunk_q <= chunk_q + 1'b1;
		end
		if (cmd.publish) begin
			out_status_q <= cmd.res_status;
			out_cycle_q <= cmd.res_cycle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= ucd_pkg::VC_RESET;
			visited_q <= '0;
			scan_q <= '0;
			depth_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) vc_q <= cfg_wdata;
			if (cmd.run_init) begin
				visited_q <= '0;
				depth_q <= '0;
			end else if (cmd.root) begin
				visited_q[scan_idx] <= 1'b1;
				depth_q <= depth_q + 1'b1;
			end else if (cmd.pop) begin
				depth_q <= depth_m1;
			end else if (cmd.check) begin
				visited_q <= visited_q | row_m;
			end else if (cmd.push) begin
				depth_q <= depth_q + 1'b1;
			end
			if (cmd.run_init || cmd.scan_clr) begin
				scan_q <= '0;
			end else if (cmd.scan_inc) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/undirected_graph_cycle_detect_top.sv @@
// Top level of the undirected graph cycle detector.
// Depends on ucd_pkg, the channel interfaces, ucd_ctrl and ucd_dp.
//
// The block stores an undirected graph of up to MAX_VERTICES vertices as adjacency rows in
// a memory and answers each request transaction with one result transaction. After reset a
// clearing pass over all MAX_VERTICES rows empties the graph before the first request
// is taken. A search request ends early at the first cycle found; its run time is set by
// the single-port adjacency read per popped vertex and by the neighbor walker, which
// examines eight candidate bits and pushes one vertex per cycle while they hold candidates.
// A new request is accepted while an earlier result still waits to be taken.
module undirected_graph_cycle_detect_top #(
	parameter int MAX_VERTICES = ucd_pkg::MAX_VERTICES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata,
	ucd_item_if.sink     item,
	ucd_result_if.source result
);

	ucd_pkg::cmd_t  cmd;
	ucd_pkg::stat_t stat;

	ucd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	ucd_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.result    (result),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for undirected_graph_cycle_detect_top, the adjacency cycle detector.
// Depends on ucd_pkg and the channel interfaces in ucd_if.sv; a scoreboard class predicts
// every result from its own copy of the graph and checks results in order.
module testbench;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 1200;
	localparam int RANDOM_ITEMS = 1200;
	localparam int PLAN_LEN = 14;
	localparam logic [6:0] VC_PLAN [PLAN_LEN] = '{7'd1, 7'd2, 7'd64, 7'd9, 7'd0, 7'd127,
		7'd4, 7'd33, 7'd64, 7'd16, 7'd100, 7'd6, 7'd64, 7'd24};

	class cycle_scoreboard;
		typedef struct packed {
			logic status;
			logic cycle_found;
		} verdict_t;

		logic [63:0] adj_rows [64];
		logic [6:0] vertex_count;
		verdict_t verdicts_due [$];
		int errors;

		function new();
			foreach (adj_rows[i]) adj_rows[i] = '0;
			vertex_count = ucd_pkg::VC_RESET;
			errors = 0;
		endfunction

		function void set_vertex_count(logic [6:0] value);
			vertex_count = value;
		endfunction

		function int vertex_limit();
			return (vertex_count > 7'd64) ? 64 : int'(vertex_count);
		endfunction

		function int outstanding();
			return verdicts_due.size();
		endfunction

		function bit search_for_loop();
			int n;
			int depth;
			int cur;
			logic [63:0] seen;
			logic [5:0] parent [64];
			logic [5:0] stack_q [64];
			n = vertex_limit();
			seen = '0;
			depth = 0;
			for (int root = 0; root < n; root++) begin
				if (seen[root])
					continue;
				seen[root] = 1'b1;
				parent[root] = 6'(root);
				stack_q[depth] = 6'(root);
				depth++;
				while (depth > 0) begin
					depth--;
					cur = int'(stack_q[depth]);
					for (int nb = 0; nb < n; nb++) begin
						if (!adj_rows[cur][nb])
							continue;
						if (!seen[nb]) begin
							seen[nb] = 1'b1;
							parent[nb] = 6'(cur);
							if (depth < 64) begin
								stack_q[depth] = 6'(nb);
								depth++;
							end
						end else if (int'(parent[cur]) != nb) begin
							return 1'b1;
						end
					end
				end
			end
			return 1'b0;
		endfunction

		function void note_request(logic [1:0] req, logic [5:0] a, logic [5:0] b);
			verdict_t v;
			int lim;
			v = '0;
			lim = vertex_limit();
			case (req)
				ucd_pkg::REQ_ADD: begin
					if (int'(a) >= lim || int'(b) >= lim || a == b) begin
						v.status = 1'b1;
					end else begin
						adj_rows[a][b] = 1'b1;
						adj_rows[b][a] = 1'b1;
					end
				end
				ucd_pkg::REQ_CLEAR: begin
					foreach (adj_rows[i]) adj_rows[i] = '0;
				end
				ucd_pkg::REQ_RUN: begin
					v.cycle_found = search_for_loop();
				end
				default: begin
				end
			endcase
			verdicts_due.push_back(v);
		endfunction

		task report_mismatch(string msg);
			$display("%0t: mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic status, logic cycle_found);
			verdict_t want;
			if (verdicts_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%b cycle_found=%b",
					status, cycle_found));
				return;
			end
			want = verdicts_due.pop_front();
			if (status !== want.status)
				report_mismatch($sformatf("status %b, expected %b", status, want.status));
			if (cycle_found !== want.cycle_found)
				report_mismatch($sformatf("cycle_found %b, expected %b", cycle_found,
					want.cycle_found));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [6:0] cfg_wdata;
	bit steady = 1'b0;
	int hold_asked = 0;
	int random_sent = 0;
	cycle_scoreboard sb = new();

	ucd_item_if item();
	ucd_result_if result();

	undirected_graph_cycle_detect_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(item),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		int hold_taken;
		int hold_left;
		hold_taken = 0;
		hold_left = 0;
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result.valid && result.ready)
				sb.check_result(result.status, result.cycle_found);
			if (hold_taken != hold_asked) begin
				hold_taken = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else if (steady || !arst_n) begin
				result.ready <= arst_n;
			end else begin
				result.ready <= ($urandom_range(99) >= 17);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item.valid && item.ready) || (result.valid && result.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench failed");
		$finish;
	end

	task automatic send_item(input logic [1:0] req, input logic [5:0] a, input logic [5:0] b);
		if (!steady) begin
			while ($urandom_range(99) < 17) begin
				item.valid <= 1'b0;
				@(posedge clk);
			end
		end
		item.valid <= 1'b1;
		item.req_type <= req;
		item.vertex_a <= a;
		item.vertex_b <= b;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		sb.note_request(req, a, b);
	endtask

	task automatic wait_idle();
		item.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [6:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_vertex_count(value);
		cfg_we <= 1'b0;
	endtask

	task automatic add_random_edge(input int lim);
		logic [5:0] a;
		logic [5:0] b;
		a = 6'($urandom_range(lim > 0 ? lim - 1 : 0));
		b = 6'($urandom_range(lim > 0 ? lim - 1 : 0));
		send_item(ucd_pkg::REQ_ADD, a, b);
		random_sent++;
	endtask

	task automatic build_forest(input int lim);
		logic [5:0] child;
		logic [5:0] up;
		for (int v = 1; v < lim; v++) begin
			if ($urandom_range(99) < 60) begin
				child = 6'(v);
				up = 6'($urandom_range(v - 1));
				if ($urandom_range(9) == 0)
					send_item(ucd_pkg::REQ_ADD, 6'($urandom), 6'($urandom));
				else if ($urandom_range(1))
					send_item(ucd_pkg::REQ_ADD, child, up);
				else
					send_item(ucd_pkg::REQ_ADD, up, child);
				random_sent++;
			end
		end
	endtask

	initial begin
		int phase;
		int lim;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item.valid = 1'b0;
		item.req_type = ucd_pkg::REQ_ADD;
		item.vertex_a = '0;
		item.vertex_b = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_item(ucd_pkg::REQ_ADD, 6'd0, 6'd63);
		send_item(ucd_pkg::REQ_ADD, 6'd63, 6'd0);
		send_item(ucd_pkg::REQ_ADD, 6'd5, 6'd5);
		send_item(ucd_pkg::REQ_RUN, 6'd0, 6'd0);
		send_item(ucd_pkg::REQ_ADD, 6'd0, 6'd1);
		send_item(ucd_pkg::REQ_ADD, 6'd1, 6'd63);
		send_item(ucd_pkg::REQ_RUN, 6'd63, 6'd63);
		send_item(REQ_UNUSED, 6'd63, 6'd63);
		send_item(REQ_UNUSED, 6'd0, 6'd0);
		send_item(ucd_pkg::REQ_CLEAR, 6'd21, 6'd42);
		send_item(ucd_pkg::REQ_RUN, 6'd42, 6'd21);
		send_item(ucd_pkg::REQ_ADD, 6'd10, 6'd40);
		send_item(ucd_pkg::REQ_ADD, 6'd40, 6'd50);
		send_item(ucd_pkg::REQ_ADD, 6'd50, 6'd10);
		write_vertex_count(7'd20);
		send_item(ucd_pkg::REQ_RUN, 6'd0, 6'd0);
		send_item(ucd_pkg::REQ_ADD, 6'd10, 6'd40);
		send_item(ucd_pkg::REQ_ADD, 6'd19, 6'd0);
		write_vertex_count(7'd0);
		send_item(ucd_pkg::REQ_ADD, 6'd0, 6'd1);
		send_item(ucd_pkg::REQ_RUN, 6'd0, 6'd0);
		write_vertex_count(7'd127);
		send_item(ucd_pkg::REQ_ADD, 6'd63, 6'd62);
		send_item(ucd_pkg::REQ_RUN, 6'd0, 6'd0);
		send_item(ucd_pkg::REQ_CLEAR, 6'd0, 6'd0);

		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			write_vertex_count(VC_PLAN[phase % PLAN_LEN]);
			lim = sb.vertex_limit();
			steady = (phase == 2 || phase == 3);
			if (phase == 5) begin
				hold_asked++;
				repeat (30) add_random_edge(lim);
			end
			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(99) < 80) begin
					if ($urandom_range(99) < 70) begin
						send_item(ucd_pkg::REQ_CLEAR, 6'($urandom), 6'($urandom));
						random_sent++;
					end
					build_forest(lim);
					if ($urandom_range(1))
						add_random_edge(lim);
					send_item(ucd_pkg::REQ_RUN, 6'($urandom), 6'($urandom));
					random_sent++;
				end else begin
					repeat ($urandom_range(3, 12)) begin
						send_item(2'($urandom_range(3)), 6'($urandom), 6'($urandom));
						random_sent++;
					end
				end
				if ($urandom_range(99) < 15)
					wait_idle();
			end
			phase++;
		end

		item.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
